@@ hdl/vbpd_pkg.sv @@
// Shared types, constants and the pixel decode function for the byte pair pixel decoder.
`default_nettype none

package vbpd_pkg;

  // Fixed field widths
  localparam int unsigned AddrW   = 13;
  localparam int unsigned ColumnW = 6;
  localparam int unsigned RowW    = 8;
  localparam int unsigned PixW    = 5;

  // Defaults for the top-level parameters
  localparam int unsigned BytesPerLineDef = 40;
  localparam int unsigned QueueDepthDef   = 2;

  // Palette screen: colour bits that pick which fixed colour is "on"
  localparam logic [7:0] FixedSelMask  = 8'h78;
  localparam logic [7:0] FixedSelMatch = 8'h30;

  // Fixed palette-screen colours
  localparam logic [PixW-1:0] FixedColA = 5'd16;
  localparam logic [PixW-1:0] FixedColB = 5'd17;

  // Display modes
  typedef enum logic [3:0] {
    MODE_BMP4    = 4'd0,
    MODE_PAGE1   = 4'd1,
    MODE_PAGE2   = 4'd2,
    MODE_STACK2  = 4'd3,
    MODE_COL80   = 4'd4,
    MODE_STACK4  = 4'd5,
    MODE_BMP4B   = 4'd6,
    MODE_BMP16   = 4'd7,
    MODE_PALETTE = 4'd8,
    MODE_COL40   = 4'd9
  } mode_e;

  typedef logic [PixW-1:0] pix_t;
  // Index 0 is the leftmost pixel
  typedef pix_t [15:0] pix16_t;

  // One decoded byte pair, as it waits between front and back
  typedef struct packed {
    pix16_t             pixels;
    logic [ColumnW-1:0] column;
    logic [RowW-1:0]    row;
  } entry_t;

  // Decode one form/colour byte pair into sixteen 80-column pixels
  function automatic pix16_t decode_pixels(logic [3:0] cmd, logic fixed_area,
                                           logic [7:0] f, logic [7:0] c);
    pix16_t px;
    pix_t   on_v;
    pix_t   off_v;
    pix_t   v;
    px = '0;
    on_v = '0;
    off_v = '0;
    v = '0;
    case (mode_e'(cmd))
      MODE_BMP4: begin
        for (int i = 0; i < 8; i++) begin
          px[2*i]   = {3'b000, f[7-i], c[7-i]};
          px[2*i+1] = {3'b000, f[7-i], c[7-i]};
        end
      end
      MODE_PAGE1, MODE_PAGE2: begin
        on_v = (mode_e'(cmd) == MODE_PAGE1) ? 5'd1 : 5'd2;
        for (int i = 0; i < 8; i++) begin
          px[2*i]   = f[7-i] ? on_v : 5'd0;
          px[2*i+1] = f[7-i] ? on_v : 5'd0;
        end
      end
      MODE_STACK2: begin
        for (int i = 0; i < 8; i++) begin
          v = f[7-i] ? 5'd1 : (c[7-i] ? 5'd2 : 5'd0);
          px[2*i]   = v;
          px[2*i+1] = v;
        end
      end
      MODE_COL80: begin
        for (int i = 0; i < 8; i++) begin
          px[i]   = {4'b0000, f[7-i]};
          px[i+8] = {4'b0000, c[7-i]};
        end
      end
      MODE_STACK4: begin
        // page priority: form high nibble, form low, colour high, colour low
        for (int i = 0; i < 4; i++) begin
          if (f[7-i])      v = 5'd1;
          else if (f[3-i]) v = 5'd2;
          else if (c[7-i]) v = 5'd3;
          else if (c[3-i]) v = 5'd4;
          else             v = 5'd0;
          for (int k = 0; k < 4; k++) begin
            px[4*i+k] = v;
          end
        end
      end
      MODE_BMP4B: begin
        for (int i = 0; i < 4; i++) begin
          px[2*i]     = {3'b000, f[7-2*i], f[6-2*i]};
          px[2*i+1]   = {3'b000, f[7-2*i], f[6-2*i]};
          px[2*i+8]   = {3'b000, c[7-2*i], c[6-2*i]};
          px[2*i+9]   = {3'b000, c[7-2*i], c[6-2*i]};
        end
      end
      MODE_BMP16: begin
        for (int k = 0; k < 4; k++) begin
          px[k]    = {1'b0, f[7:4]};
          px[k+4]  = {1'b0, f[3:0]};
          px[k+8]  = {1'b0, c[7:4]};
          px[k+12] = {1'b0, c[3:0]};
        end
      end
      default: begin
        if ((mode_e'(cmd) == MODE_PALETTE) && fixed_area) begin
          if ((c & FixedSelMask) == FixedSelMatch) begin
            on_v  = FixedColA;
            off_v = FixedColB;
          end else begin
            on_v  = FixedColB;
            off_v = FixedColA;
          end
        end else begin
          // Else (40 columns, unused codes, palette outside fixed area): fg/bg, inverted brightness bits
          on_v  = {1'b0, ~c[6], c[5:3]};
          off_v = {1'b0, ~c[7], c[2:0]};
        end
        for (int i = 0; i < 8; i++) begin
          px[2*i]   = f[7-i] ? on_v : off_v;
          px[2*i+1] = f[7-i] ? on_v : off_v;
        end
      end
    endcase
    return px;
  endfunction

endpackage

`default_nettype wire

@@ hdl/vbpd_front.sv @@
// Front end: takes a transaction, decodes pixels and splits the address into column and row.
`default_nettype none

module vbpd_front import vbpd_pkg::*; #(
  parameter int unsigned BYTES_PER_LINE = BytesPerLineDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [AddrW-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [3:0]         command_i,
  input  wire logic [AddrW-1:0]   address_i,
  input  wire logic [7:0]         form_byte_i,
  input  wire logic [7:0]         colour_byte_i,
  output      logic               push_valid_o,
  input  wire logic               push_ready_i,
  output      entry_t             push_entry_o
);

  // Reciprocal of the line length, exact enough for one correction step
  localparam int unsigned RecipShift = AddrW + 7;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << RecipShift) / BYTES_PER_LINE);
  localparam int unsigned ProdW      = AddrW + RecipW;
  localparam int unsigned BplW       = $clog2(BYTES_PER_LINE + 1);
  localparam int unsigned RemW       = $clog2(2 * BYTES_PER_LINE) + 1;
  localparam logic [BplW-1:0] Bpl    = BplW'(BYTES_PER_LINE);

  logic [AddrW-1:0] area_end_q;

  logic             s1_valid_q, s1_valid_d;
  pix16_t           s1_pix_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [AddrW-1:0] s1_qest_q;

  logic                  accept;
  logic                  push;
  logic [ProdW-1:0]      prod;
  logic [AddrW+BplW-1:0] qb;
  logic [AddrW+BplW-1:0] rem_w;
  logic [RemW-1:0]       rem;
  logic [AddrW-1:0]      quot;
  logic [RemW-1:0]       rmd;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_end_q <= '0;
    end else if (cfg_we_i) begin
      area_end_q <= cfg_data_i;
    end
  end

  // Stage 1 takes a new transaction whenever it is empty or drains this cycle
  assign push       = s1_valid_q & push_ready_i;
  assign in_ready_o = ~s1_valid_q | push_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Quotient estimate: never high, at most one low
  assign prod = ProdW'(address_i) * ProdW'(Recip);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= decode_pixels(command_i, address_i < area_end_q, form_byte_i, colour_byte_i);
      s1_addr_q <= address_i;
      s1_qest_q <= AddrW'(prod >> RecipShift);
    end
  end

  // Stage 2: remainder and one correction step
  assign qb    = (AddrW+BplW)'(s1_qest_q) * (AddrW+BplW)'(Bpl);
  assign rem_w = (AddrW+BplW)'(s1_addr_q) - qb;
  assign rem   = RemW'(rem_w);

  always_comb begin
    if (rem >= RemW'(Bpl)) begin
      quot = s1_qest_q + AddrW'(1);
      rmd  = rem - RemW'(Bpl);
    end else begin
      quot = s1_qest_q;
      rmd  = rem;
    end
  end

  assign push_valid_o        = s1_valid_q;
  assign push_entry_o.pixels = s1_pix_q;
  assign push_entry_o.column = ColumnW'(rmd);
  assign push_entry_o.row    = RowW'(quot);

endmodule

`default_nettype wire

@@ hdl/vbpd_queue.sv @@
// Short FIFO of decoded byte pairs between front end and emitter.
`default_nettype none

module vbpd_queue import vbpd_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_valid_i,
  output      logic   push_ready_o,
  input  wire entry_t push_entry_i,
  output      logic   pop_valid_o,
  input  wire logic   pop_ready_i,
  output      entry_t pop_entry_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = count_q != CntW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/vbpd_back.sv @@
// Emitter: sends each decoded byte pair as a left half and then a right half.
`default_nettype none

module vbpd_back import vbpd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               pop_valid_i,
  output      logic               pop_ready_o,
  input  wire entry_t             pop_entry_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      pix_t [7:0]         half_pix_o,
  output      logic [ColumnW-1:0] column_o,
  output      logic [RowW-1:0]    row_o,
  output      logic               last_half_o
);

  logic   valid_q, valid_d;
  logic   half_q, half_d;
  entry_t entry_q;
  logic   load;
  logic   out_fire;

  assign out_fire    = valid_q & out_ready_i;
  // Next entry may load when the right half leaves, or when idle
  assign pop_ready_o = ~valid_q | (out_ready_i & half_q);
  assign load        = pop_valid_i & pop_ready_o;

  always_comb begin
    valid_d = valid_q;
    half_d  = half_q;
    if (load) begin
      valid_d = 1'b1;
      half_d  = 1'b0;
    end else if (out_fire) begin
      if (half_q) begin
        valid_d = 1'b0;
      end else begin
        half_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= pop_entry_i;
    end
  end

  // Half select
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      half_pix_o[j] = half_q ? entry_q.pixels[j+8] : entry_q.pixels[j];
    end
  end

  assign out_valid_o = valid_q;
  assign column_o    = entry_q.column;
  assign row_o       = entry_q.row;
  assign last_half_o = half_q;

endmodule

`default_nettype wire

@@ hdl/video_byte_pair_pixel_decoder_top.sv @@
// Top level of the byte pair pixel decoder: front end, queue and emitter.
//
//  Channel  Direction  Handshake                 Contents
//  cfg      in         cfg_we_i                  cfg_data_i: palette_area_end
//  in       in         in_valid_i / in_ready_o   command, address, form_byte, colour_byte
//  out      out        out_valid_o / out_ready_i pixel_a..h, column, row, last_half
//
// Each input transaction yields two output transactions, left half then right half.
// The emitter's two output beats per input limit the sustained input rate.
// An input passes through the stage 1 register, the queue and the emitter register.
// Reset clears the palette area end to 0 and empties all stages; no clearing pass.
// A queue, 2 entries deep by default, decouples the decode pipeline from output stalls.
`default_nettype none

module video_byte_pair_pixel_decoder_top import vbpd_pkg::*; #(
  parameter int unsigned BYTES_PER_LINE = BytesPerLineDef,
  parameter int unsigned QUEUE_DEPTH    = QueueDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [AddrW-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [3:0]         command_i,
  input  wire logic [AddrW-1:0]   address_i,
  input  wire logic [7:0]         form_byte_i,
  input  wire logic [7:0]         colour_byte_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [PixW-1:0]    pixel_a_o,
  output      logic [PixW-1:0]    pixel_b_o,
  output      logic [PixW-1:0]    pixel_c_o,
  output      logic [PixW-1:0]    pixel_d_o,
  output      logic [PixW-1:0]    pixel_e_o,
  output      logic [PixW-1:0]    pixel_f_o,
  output      logic [PixW-1:0]    pixel_g_o,
  output      logic [PixW-1:0]    pixel_h_o,
  output      logic [ColumnW-1:0] column_o,
  output      logic [RowW-1:0]    row_o,
  output      logic               last_half_o
);

  logic       push_valid;
  logic       push_ready;
  entry_t     push_entry;
  logic       pop_valid;
  logic       pop_ready;
  entry_t     pop_entry;
  pix_t [7:0] half_pix;

  vbpd_front #(
    .BYTES_PER_LINE(BYTES_PER_LINE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .address_i    (address_i),
    .form_byte_i  (form_byte_i),
    .colour_byte_i(colour_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  vbpd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_entry_i(push_entry),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_entry_o (pop_entry)
  );

  vbpd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_entry_i(pop_entry),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .half_pix_o (half_pix),
    .column_o   (column_o),
    .row_o      (row_o),
    .last_half_o(last_half_o)
  );

  assign pixel_a_o = half_pix[0];
  assign pixel_b_o = half_pix[1];
  assign pixel_c_o = half_pix[2];
  assign pixel_d_o = half_pix[3];
  assign pixel_e_o = half_pix[4];
  assign pixel_f_o = half_pix[5];
  assign pixel_g_o = half_pix[6];
  assign pixel_h_o = half_pix[7];

`ifndef SYNTHESIS
  // A left half is always followed at once by its right half
  a_right_follows_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_half_o |=> out_valid_o && last_half_o)
    else $error("right half missing after left half");

  // Both halves carry the same column and row
  a_halves_same_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_half_o |=> $stable(column_o) && $stable(row_o))
    else $error("column/row changed between halves");

  // Remainder correction leaves the column inside the line
  a_column_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (column_o < BYTES_PER_LINE))
    else $error("column out of range");

  // An entry waiting in the queue is always taken by an idle emitter and shown first as its left half
  a_no_stuck_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid && !out_valid_o |=> out_valid_o && !last_half_o)
    else $error("queued entry not loaded into idle emitter");
`endif

endmodule

`default_nettype wire
